/* sv/set_assoc_cache_fifo_lookup_unit_defines.svh */
`ifndef SET_ASSOC_CACHE_FIFO_LOOKUP_UNIT_DEFINES_SVH
`define SET_ASSOC_CACHE_FIFO_LOOKUP_UNIT_DEFINES_SVH

// Both macros expect signals named clk and rst in the module that uses them.

// Same-cycle implication.
`define SACF_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sacf assertion failed");

// Next-cycle implication.
`define SACF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sacf assertion failed");

`endif

/* sv/sacf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sacf_pkg;

  localparam int DEF_SETS = 64;
  localparam int DEF_WAYS = 4;

  localparam int ADDR_W   = 32;
  localparam int OFFSET_W = 5;
  localparam int WAY_W    = 3;
  localparam int CNT_W    = 32;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  localparam logic [OFFSET_W-1:0] OFFSET_RESET = 5'd4;
  localparam logic [CNT_W-1:0]    CNT_MAX      = '1;

  // Register index as decoded from paddr[2].
  localparam logic REG_OFFSET_BITS = 1'b0;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_MOD   = 4'b0100,
    ST_LOOK  = 4'b1000
  } sacf_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sacf_idx_stat_t;

  typedef struct packed {
    logic rd;
    logic upd;
    logic clr;
  } sacf_mem_ctl_t;

endpackage

`default_nettype wire

/* sv/sacf_set_index.sv */
`timescale 1ns / 1ps
`default_nettype none

module sacf_set_index #(
  parameter int SETS  = sacf_pkg::DEF_SETS,
  parameter int SET_W = 6
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [sacf_pkg::ADDR_W-1:0] block,
  output sacf_pkg::sacf_idx_stat_t    stat,
  output logic [SET_W-1:0]            set_idx
);
  import sacf_pkg::*;

  localparam bit IS_POW2 = ((SETS & (SETS - 1)) == 0);

  generate
    if (SETS == 1) begin : g_single
      assign stat.busy = 1'b0;
      assign stat.done = start;
      assign set_idx   = '0;
    end else if (IS_POW2) begin : g_mask
      assign stat.busy = 1'b0;
      assign stat.done = start;
      assign set_idx   = block[SET_W-1:0];
    end else begin : g_recip
      localparam int RECIP_SH = $clog2(SETS);
      localparam int PROD_W   = 2 * ADDR_W + 1;
      localparam int QUO_W    = PROD_W - ADDR_W - RECIP_SH;
      // Reciprocal of SETS scaled by 2^(ADDR_W+RECIP_SH) and rounded up. It
      // fits in ADDR_W+1 bits and gives the exact quotient of any block.
      localparam logic [63:0] RECIP_64 =
        ((64'd1 << (ADDR_W + RECIP_SH)) + 64'(SETS) - 64'd1) / 64'(SETS);
      localparam logic [ADDR_W:0]   RECIP  = RECIP_64[ADDR_W:0];
      localparam logic [ADDR_W-1:0] SETS_A = ADDR_W'(SETS);

      logic [ADDR_W-1:0] blk_q;
      logic [PROD_W-1:0] prod;
      logic [ADDR_W-1:0] quo;
      logic [ADDR_W-1:0] diff;
      logic [SET_W-1:0]  rem;
      logic              mul_v;
      logic              sub_v;
      logic              done_q;

      assign quo  = ADDR_W'(prod[PROD_W-1 -: QUO_W]);
      assign diff = blk_q - quo * SETS_A;

      always_ff @(posedge clk) begin
        if (rst) begin
          mul_v  <= 1'b0;
          sub_v  <= 1'b0;
          done_q <= 1'b0;
        end else begin
          mul_v  <= start;
          sub_v  <= mul_v;
          done_q <= sub_v;
        end
      end

      // Register the block, multiply by the reciprocal, then subtract the
      // quotient times SETS to leave the remainder.
      always_ff @(posedge clk) begin
        if (start) begin
          blk_q <= block;
        end
        if (mul_v) begin
          prod <= PROD_W'(blk_q) * PROD_W'(RECIP);
        end
        if (sub_v) begin
          rem <= diff[SET_W-1:0];
        end
      end

      assign stat.busy = mul_v || sub_v;
      assign stat.done = done_q;
      assign set_idx   = rem;
    end
  endgenerate

endmodule

`default_nettype wire

/* sv/sacf_tag_store.sv */
`timescale 1ns / 1ps
`default_nettype none

module sacf_tag_store #(
  parameter int SETS  = sacf_pkg::DEF_SETS,
  parameter int WAYS  = sacf_pkg::DEF_WAYS,
  parameter int SET_W = 6,
  parameter int PTR_W = 2
) (
  input  logic                        clk,
  input  sacf_pkg::sacf_mem_ctl_t     ctl,
  input  logic [SET_W-1:0]            set_idx,
  input  logic [sacf_pkg::ADDR_W-1:0] tag,
  output logic                        hit,
  output logic [sacf_pkg::WAY_W-1:0]  way
);
  import sacf_pkg::*;

  localparam int TAGS_W = WAYS * ADDR_W;
  localparam int ROW_W  = 1 + PTR_W + TAGS_W;

  // One row per set: {full, fill pointer, tags of all ways}.
  logic [ROW_W-1:0] mem [SETS];
  logic [ROW_W-1:0] rd_row;
  logic [SET_W-1:0] lk_set;

  logic             full;
  logic [PTR_W-1:0] ptr;
  logic [PTR_W-1:0] hit_way;
  logic [PTR_W-1:0] ptr_next;
  logic             full_next;
  logic [TAGS_W-1:0] tags_next;
  logic [ROW_W-1:0] wr_row;
  logic [SET_W-1:0] wr_addr;
  logic             wr_en;

  assign full = rd_row[ROW_W-1];
  assign ptr  = rd_row[TAGS_W +: PTR_W];

  // A way is valid once filled; valid bits never clear, so ways below the
  // fill pointer are valid, and all of them once the set has wrapped.
  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if ((full || (PTR_W'(w) < ptr)) && (rd_row[w*ADDR_W +: ADDR_W] == tag)) begin
        hit     = 1'b1;
        hit_way = PTR_W'(w);
      end
    end
  end

  always_comb begin
    if (ptr == PTR_W'(WAYS - 1)) begin
      ptr_next  = '0;
      full_next = 1'b1;
    end else begin
      ptr_next  = ptr + 1'b1;
      full_next = full;
    end
    tags_next = rd_row[TAGS_W-1:0];
    tags_next[ptr*ADDR_W +: ADDR_W] = tag;
  end

  assign wr_en   = ctl.clr || (ctl.upd && !hit);
  assign wr_addr = ctl.clr ? set_idx : lk_set;
  assign wr_row  = ctl.clr ? '0 : {full_next, ptr_next, tags_next};
  assign way     = hit ? WAY_W'(hit_way) : WAY_W'(ptr);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    if (ctl.rd) begin
      rd_row <= mem[set_idx];
      lk_set <= set_idx;
    end
  end

endmodule

`default_nettype wire

/* sv/set_assoc_cache_fifo_lookup_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Signals                                   Handshake
// config    psel penable pwrite paddr pwdata prdata   APB, pready tied high
// access    address                                   start while busy is low
// result    hit way hit_count miss_count              done, one-cycle strobe
//
// When SETS is a power of two, an access first reads the set's tag row from
// the synchronous memory, then compares, writes back and counts. Otherwise
// the set index comes from a three-stage reciprocal multiply unit.
// After reset the block is busy while it clears each set row.
// The result register is loaded as busy drops, so the receiver never stalls.

module set_assoc_cache_fifo_lookup_unit #(
  parameter int SETS = sacf_pkg::DEF_SETS,
  parameter int WAYS = sacf_pkg::DEF_WAYS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [sacf_pkg::ADDR_W-1:0] address,
  output logic                        busy,
  output logic                        done,
  output logic                        hit,
  output logic [sacf_pkg::WAY_W-1:0]  way,
  output logic [sacf_pkg::CNT_W-1:0]  hit_count,
  output logic [sacf_pkg::CNT_W-1:0]  miss_count,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sacf_pkg::APB_AW-1:0] paddr,
  input  logic [sacf_pkg::APB_DW-1:0] pwdata,
  output logic [sacf_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);
  import sacf_pkg::*;
`include "set_assoc_cache_fifo_lookup_unit_defines.svh"

  localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int PTR_W = (WAYS > 1) ? $clog2(WAYS) : 1;

  sacf_state_t       state;
  sacf_state_t       state_next;
  logic [SET_W-1:0]  clr_idx;
  logic [OFFSET_W-1:0] offset_bits;
  logic [ADDR_W-1:0] block_now;
  logic [ADDR_W-1:0] block_q;
  logic              accept;

  sacf_idx_stat_t    si_stat;
  logic [SET_W-1:0]  si_set;
  sacf_mem_ctl_t     mem_ctl;
  logic [SET_W-1:0]  mem_set;
  logic              ts_hit;
  logic [WAY_W-1:0]  ts_way;

  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == REG_OFFSET_BITS) ? APB_DW'(offset_bits) : '0;
  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign block_now = address >> offset_bits;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits <= OFFSET_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_OFFSET_BITS)) begin
      offset_bits <= pwdata[OFFSET_W-1:0];
    end
  end

  sacf_set_index #(
    .SETS  (SETS),
    .SET_W (SET_W)
  ) u_set_index (
    .clk     (clk),
    .rst     (rst),
    .start   (accept),
    .block   (block_now),
    .stat    (si_stat),
    .set_idx (si_set)
  );

  always_comb begin
    mem_ctl.clr = (state == ST_CLEAR);
    mem_ctl.rd  = si_stat.done && (accept || (state == ST_MOD));
    mem_ctl.upd = (state == ST_LOOK);
    mem_set     = (state == ST_CLEAR) ? clr_idx : si_set;
  end

  sacf_tag_store #(
    .SETS  (SETS),
    .WAYS  (WAYS),
    .SET_W (SET_W),
    .PTR_W (PTR_W)
  ) u_tag_store (
    .clk     (clk),
    .ctl     (mem_ctl),
    .set_idx (mem_set),
    .tag     (block_q),
    .hit     (ts_hit),
    .way     (ts_way)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_idx == SET_W'(SETS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_next = si_stat.done ? ST_LOOK : ST_MOD;
        end
      end
      ST_MOD: begin
        if (si_stat.done) begin
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_idx    <= '0;
      done       <= 1'b0;
      hit_count  <= '0;
      miss_count <= '0;
    end else begin
      state <= state_next;
      done  <= (state == ST_LOOK);
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if (state == ST_LOOK) begin
        if (ts_hit) begin
          if (hit_count != CNT_MAX) begin
            hit_count <= hit_count + 1'b1;
          end
        end else if (miss_count != CNT_MAX) begin
          miss_count <= miss_count + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      block_q <= block_now;
    end
    if (state == ST_LOOK) begin
      hit <= ts_hit;
      way <= ts_way;
    end
  end

  `SACF_ASSERT_NEXT(a_look_done, state == ST_LOOK, done)
  `SACF_ASSERT_NEXT(a_accept_busy, accept, busy)
  `SACF_ASSERT_IMPL(a_mod_running, state == ST_MOD, si_stat.busy || si_stat.done)
  `SACF_ASSERT_NEXT(a_miss_counts, (state == ST_LOOK) && !ts_hit && (miss_count != CNT_MAX),
                    miss_count == $past(miss_count) + 1'b1)

endmodule

`default_nettype wire
